// ===== sv/sie_pkg.sv =====
// package for the shift input change event block
// types, field widths, op codes and register indexes; no dependencies
`timescale 1ns / 1ps

package sie_pkg;

    localparam int BYTE_W = 8;
    localparam int MOD_W  = 3;
    localparam int BIT_W  = 3;
    localparam int PIN_W  = MOD_W + BIT_W;
    localparam int OP_W   = 2;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 8;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [IDX_W-1:0] REG_MODCOUNT = 8'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_EN = 8'd2;
    localparam logic [IDX_W-1:0] REG_RELEA_EN = 8'd3;

    localparam logic [BYTE_W-1:0] DEBOUNCE_RST = 8'd10;
    localparam logic [CNT_W-1:0]  MODCOUNT_RST = 4'd1;
    localparam logic [BYTE_W-1:0] ELAPSED_MAX  = 8'hFF;

    // one byte handed to the scanner: which module, which bits to report, new levels
    typedef struct packed {
        logic [MOD_W-1:0]  mod;
        logic [BYTE_W-1:0] rep;
        logic [BYTE_W-1:0] lvl;
    } t_scan_job;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             pressed;
        logic             last;
    } t_event;

endpackage

// ===== sv/shift_input_change_events_top.sv =====
// Change detector for chained 8-bit input shift registers. A tick beat, a clear beat,
// a byte with no reportable change, or a byte that is ignored (gate closed, module out
// of range, unused op) leaves the input ready. A byte that has reportable changes is
// handed to the bit scanner, which walks its change mask one bit per cycle, a bit that
// needs an event waiting while the event output is stalled, and stops after the highest
// reportable bit; the next beat is taken in the cycle after the scan ends. Events leave
// lowest pin first, the final one of a byte marked by tlast. Stored levels live in
// flip-flops and are zero right after reset.
// top level; uses sie_pkg and sie_scan
`timescale 1ns / 1ps

module shift_input_change_events_top
    import sie_pkg::*;
#(
    parameter int MAX_MODULES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [15:0]      i_s_tdata,   // module_req[2:0], bits[10:3], zero fill
    input  logic [OP_W-1:0]  i_s_tuser,   // op[1:0]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // event_valid[0], pin[6:1], zero fill
    output logic             o_m_tuser,   // pressed[0]
    output logic             o_m_tlast,   // last_result
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    localparam int LV_IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MODULES);

    logic [BYTE_W-1:0] r_debounce;
    logic [CNT_W-1:0]  r_modcount;
    logic              r_press_en;
    logic              r_relea_en;
    logic [BYTE_W-1:0] r_elapsed;
    logic [BYTE_W-1:0] r_levels [MAX_MODULES];

    logic [MOD_W-1:0]  in_mod;
    logic [BYTE_W-1:0] in_bits;
    logic              in_acc;
    logic [CNT_W-1:0]  cnt_eff;
    logic              mod_ok;
    logic              gate_open;
    logic              byte_take;
    logic [BYTE_W-1:0] prev;
    logic [BYTE_W-1:0] rep;
    logic              scan_busy;
    logic              evt_valid;
    t_event            evt;
    t_scan_job         job;

    assign in_mod  = i_s_tdata[MOD_W-1:0];
    assign in_bits = i_s_tdata[MOD_W+BYTE_W-1:MOD_W];
    assign in_acc  = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_modcount == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (r_modcount > MAX_CNT) begin
            cnt_eff = MAX_CNT;
        end else begin
            cnt_eff = r_modcount;
        end
    end

    assign mod_ok    = {1'b0, in_mod} < cnt_eff;
    assign gate_open = r_elapsed > r_debounce;
    assign byte_take = in_acc && (i_s_tuser == OP_BYTE) && mod_ok && gate_open;
    assign prev      = r_levels[in_mod[LV_IDX_W-1:0]];
    // changed bits whose event kind is enabled
    assign rep       = (prev ^ in_bits) &
                       ((~in_bits & {BYTE_W{r_press_en}}) | (in_bits & {BYTE_W{r_relea_en}}));

    assign job.mod = in_mod;
    assign job.rep = rep;
    assign job.lvl = in_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_modcount <= MODCOUNT_RST;
            r_press_en <= 1'b1;
            r_relea_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE: r_debounce <= i_cfg_data;
                REG_MODCOUNT: r_modcount <= i_cfg_data[CNT_W-1:0];
                REG_PRESS_EN: r_press_en <= i_cfg_data[0];
                REG_RELEA_EN: r_relea_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            for (int i = 0; i < MAX_MODULES; i++) begin
                r_levels[i] <= '0;
            end
        end else if (in_acc) begin
            case (i_s_tuser)
                OP_TICK: begin
                    if (r_elapsed != ELAPSED_MAX) begin
                        r_elapsed <= r_elapsed + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_elapsed <= ELAPSED_MAX;
                    for (int i = 0; i < MAX_MODULES; i++) begin
                        r_levels[i] <= '0;
                    end
                end
                OP_BYTE: begin
                    if (byte_take) begin
                        r_levels[in_mod[LV_IDX_W-1:0]] <= in_bits;
                        // last module of the scan restarts the debounce window
                        if ({1'b0, in_mod} == cnt_eff - 1'b1) begin
                            r_elapsed <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    sie_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (byte_take && (rep != '0)),
        .i_job       (job),
        .o_busy      (scan_busy),
        .o_evt_valid (evt_valid),
        .i_evt_ready (i_m_tready),
        .o_evt       (evt)
    );

    assign o_s_tready  = !scan_busy;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = evt_valid;
    assign o_m_tdata   = {1'b0, evt.pin, 1'b1};
    assign o_m_tuser   = evt.pressed;
    assign o_m_tlast   = evt.last;

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byte_take && (rep != '0) |=> !o_s_tready)
        else $error("input taken during a scan");

    a_gate_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_take && ({1'b0, in_mod} == cnt_eff - 1'b1)) |=> (r_elapsed == '0))
        else $error("elapsed not restarted after last module");

    a_clear_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_tuser == OP_CLEAR)) |=> (r_elapsed == ELAPSED_MAX))
        else $error("clear did not open the gate");

endmodule

// ===== sv/sie_scan.sv =====
// bit scanner: walks a reported-change mask one bit per cycle through a shift unit, holding
// on a bit that needs an event while the output is full, and drives the event output register; uses sie_pkg
`timescale 1ns / 1ps

module sie_scan
    import sie_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_scan_job i_job,
    output logic      o_busy,
    output logic      o_evt_valid,
    input  logic      i_evt_ready,
    output t_event    o_evt
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state, n_state;
    logic [MOD_W-1:0]  r_mod,   n_mod;
    logic [BYTE_W-1:0] r_rep,   n_rep;
    logic [BYTE_W-1:0] r_lvl,   n_lvl;
    logic [BIT_W-1:0]  r_bit,   n_bit;
    logic              r_out_valid, n_out_valid;
    t_event            r_evt,   n_evt;

    logic out_free;
    logic emit;
    logic advance;
    logic rest_zero;

    assign out_free  = !r_out_valid || i_evt_ready;
    assign rest_zero = (r_rep[BYTE_W-1:1] == '0);
    // a bit that needs no event moves on even while the output is full
    assign advance   = (r_state == ST_SCAN) && (!r_rep[0] || out_free);
    assign emit      = advance && r_rep[0];

    always_comb begin
        n_state     = r_state;
        n_mod       = r_mod;
        n_rep       = r_rep;
        n_lvl       = r_lvl;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_evt_ready;
        n_evt       = r_evt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_mod   = i_job.mod;
                    n_rep   = i_job.rep;
                    n_lvl   = i_job.lvl;
                    n_bit   = '0;
                end
            end
            ST_SCAN: begin
                if (r_rep == '0) begin
                    n_state = ST_IDLE;
                end else if (advance) begin
                    n_rep = {1'b0, r_rep[BYTE_W-1:1]};
                    n_lvl = {1'b0, r_lvl[BYTE_W-1:1]};
                    n_bit = r_bit + 1'b1;
                    if (rest_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (emit) begin
            n_out_valid   = 1'b1;
            n_evt.pin     = {r_mod, r_bit};
            n_evt.pressed = !r_lvl[0];
            n_evt.last    = rest_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mod <= n_mod;
        r_rep <= n_rep;
        r_lvl <= n_lvl;
        r_bit <= n_bit;
        r_evt <= n_evt;
    end

    assign o_busy      = (r_state == ST_SCAN);
    assign o_evt_valid = r_out_valid;
    assign o_evt       = r_evt;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("scan started while busy");

    a_rise_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SCAN))
        else $error("event appeared without a scan");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && rest_zero) |=> (r_state == ST_IDLE))
        else $error("scan went on after the last event");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_evt_ready) |=> (r_out_valid && $stable(r_evt)))
        else $error("pending event overwritten");

endmodule

// ===== tb/tb.sv =====
// self-checking bench for shift_input_change_events_top: directed table then random scans
// and beats, every event beat compared against a cycle-free model of the change detector
// depends on sie_pkg and the rtl under sv/
`timescale 1ns / 1ps

module tb
    import sie_pkg::*;
();

    localparam int MODULES       = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int MAX_GAP       = 100;
    localparam int PHASE_LEN     = 103;
    localparam int ITEMS_PER_SET = 39;
    localparam int MAX_PRINTS    = 100;

    localparam logic [OP_W-1:0]  OP_SPARE   = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNUSED = 8'd9;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // idx is only looked at on register rows, val is the byte or the register data
    typedef struct packed {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [MOD_W-1:0]  mod;
        logic [7:0]        val;
        logic              typed;
        logic [3:0]        count;
        logic [PIN_W-1:0]  pin;
        logic              pressed;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] deb;
        logic [7:0] cnt;
        logic [7:0] pen;
        logic [7:0] ren;
    } t_cfg_set;

    localparam int NUM_DIR = 40;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        // gate closed right after reset
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd7, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_CLEAR, REG_DEBOUNCE, 3'd5, 8'h5A, 1'b1, 4'd0, 6'd0,  1'b0},
        // elapsed saturates at max instead of wrapping
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'h01, 1'b1, 4'd1, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_SPARE, REG_DEBOUNCE, 3'd7, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_CLEAR, REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        // module beyond the count
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd1, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'hFF, 1'b1, 4'd8, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_DEBOUNCE, 3'd0, 8'd1,  1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_MODCOUNT, 3'd0, 8'd8,  1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_UNUSED,   3'd0, 8'hA5, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_CLEAR, REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd7, 8'hFF, 1'b1, 4'd8, 6'd56, 1'b0},
        // elapsed equal to debounce still blocks, one more tick opens
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd7, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd7, 8'h00, 1'b1, 4'd8, 6'd56, 1'b1},
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd3, 8'hA5, 1'b0, 4'd0, 6'd0,  1'b0},
        // presses off: only the rising bits report
        '{ROW_CFG,  OP_TICK,  REG_PRESS_EN, 3'd0, 8'h00, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd3, 8'h5A, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_PRESS_EN, 3'd0, 8'h01, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_RELEA_EN, 3'd0, 8'h00, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd3, 8'h00, 1'b0, 4'd0, 6'd0,  1'b0},
        // both kinds off: change stored silently
        '{ROW_CFG,  OP_TICK,  REG_PRESS_EN, 3'd0, 8'h00, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd3, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_DEBOUNCE, 3'd0, 8'hFF, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_MODCOUNT, 3'd0, 8'hFF, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_PRESS_EN, 3'd0, 8'h01, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_RELEA_EN, 3'd0, 8'hFF, 1'b0, 4'd0, 6'd0,  1'b0},
        // debounce at max never opens, even after a clear
        '{ROW_ITEM, OP_CLEAR, REG_DEBOUNCE, 3'd0, 8'h00, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        // module count of zero acts as one
        '{ROW_CFG,  OP_TICK,  REG_DEBOUNCE, 3'd0, 8'h00, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_CFG,  OP_TICK,  REG_MODCOUNT, 3'd0, 8'h10, 1'b0, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd1, 8'hFF, 1'b1, 4'd0, 6'd0,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'h80, 1'b1, 4'd1, 6'd7,  1'b0},
        '{ROW_ITEM, OP_BYTE,  REG_DEBOUNCE, 3'd0, 8'h80, 1'b1, 4'd0, 6'd0,  1'b0}
    };

    localparam int NUM_SETS = 6;
    localparam t_cfg_set RAND_SETS [NUM_SETS] = '{
        '{8'd1,   8'd4,  8'd1, 8'd1},
        '{8'd0,   8'd8,  8'd1, 8'd0},
        '{8'd3,   8'd15, 8'd0, 8'd1},
        '{8'd255, 8'd2,  8'd1, 8'd1},
        '{8'd0,   8'd0,  8'd1, 8'd1},
        '{8'd2,   8'd7,  8'd1, 8'd1}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [15:0]      i_s_tdata;
    logic [OP_W-1:0]  i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [7:0]       o_m_tdata;
    logic             o_m_tuser;
    logic             o_m_tlast;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [7:0]       i_cfg_data;

    // typed-in expectation travelling with a directed beat
    logic             directed_check;
    logic [3:0]       directed_count;
    logic [PIN_W-1:0] directed_pin;
    logic             directed_pressed;

    // model state
    logic [7:0]       mirror_levels [MODULES];
    logic [7:0]       mirror_elapsed;
    logic [7:0]       cfg_debounce;
    logic [CNT_W-1:0] cfg_modcount;
    logic             cfg_press_en;
    logic             cfg_release_en;
    t_event           pending_events [$];

    t_event mon_ev;
    int     queued;
    int     quiet_cycles;
    int     mismatch_count = 0;
    int     items_sent = 0;
    int     send_idle = 25;
    int     recv_idle = 82;

    shift_input_change_events_top #(
        .MAX_MODULES(MODULES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_mods();
        if (cfg_modcount == '0)
            return 1;
        if (cfg_modcount > MODULES)
            return MODULES;
        return int'(cfg_modcount);
    endfunction

    // events a beat causes, lowest pin first, tail marked last
    function automatic void predict_change_events(logic [OP_W-1:0] op, logic [MOD_W-1:0] m,
                                                  logic [7:0] lv);
        logic [7:0] prev;
        int         first;
        int         mods;
        t_event     ev;
        mods = active_mods();
        case (op)
            OP_TICK: begin
                if (mirror_elapsed != ELAPSED_MAX)
                    mirror_elapsed = mirror_elapsed + 8'd1;
            end
            OP_CLEAR: begin
                foreach (mirror_levels[j])
                    mirror_levels[j] = '0;
                mirror_elapsed = ELAPSED_MAX;
            end
            OP_BYTE: begin
                if (int'(m) < mods && mirror_elapsed > cfg_debounce) begin
                    prev  = mirror_levels[m];
                    first = pending_events.size();
                    for (int b = 0; b < 8; b++) begin
                        if (prev[b] != lv[b] &&
                            ((!lv[b] && cfg_press_en) || (lv[b] && cfg_release_en))) begin
                            ev.pin     = {m, b[2:0]};
                            ev.pressed = !lv[b];
                            ev.last    = 1'b0;
                            pending_events.push_back(ev);
                        end
                    end
                    if (pending_events.size() > first) begin
                        ev = pending_events.pop_back();
                        ev.last = 1'b1;
                        pending_events.push_back(ev);
                    end
                    mirror_levels[m] = lv;
                    if (int'(m) == mods - 1)
                        mirror_elapsed = '0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle);

    // predicts on every accepted input beat, checks every accepted event beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mirror_levels[j])
                mirror_levels[j] = '0;
            mirror_elapsed = '0;
            cfg_debounce   = DEBOUNCE_RST;
            cfg_modcount   = MODCOUNT_RST;
            cfg_press_en   = 1'b1;
            cfg_release_en = 1'b1;
            pending_events.delete();
            quiet_cycles   = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: cfg_debounce   = i_cfg_data;
                    REG_MODCOUNT: cfg_modcount   = i_cfg_data[CNT_W-1:0];
                    REG_PRESS_EN: cfg_press_en   = i_cfg_data[0];
                    REG_RELEA_EN: cfg_release_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                queued = pending_events.size();
                predict_change_events(i_s_tuser, i_s_tdata[MOD_W-1:0],
                                      i_s_tdata[MOD_W+7:MOD_W]);
                if (directed_check) begin
                    while (pending_events.size() > queued)
                        void'(pending_events.pop_back());
                    for (int k = 0; k < int'(directed_count); k++) begin
                        mon_ev.pin     = directed_pin + k[PIN_W-1:0];
                        mon_ev.pressed = directed_pressed;
                        mon_ev.last    = (k == int'(directed_count) - 1);
                        pending_events.push_back(mon_ev);
                    end
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_events.size() == 0) begin
                    flag_mismatch($sformatf("event beat pin %0d with nothing pending",
                                            o_m_tdata[PIN_W:1]));
                end else begin
                    mon_ev = pending_events.pop_front();
                    if (o_m_tdata[0] !== 1'b1)
                        flag_mismatch($sformatf("event_valid low, pin %0d", mon_ev.pin));
                    if (o_m_tdata[PIN_W:1] !== mon_ev.pin)
                        flag_mismatch($sformatf("pin %0d, expected %0d",
                                                o_m_tdata[PIN_W:1], mon_ev.pin));
                    if (o_m_tuser !== mon_ev.pressed)
                        flag_mismatch($sformatf("pressed %b on pin %0d, expected %b",
                                                o_m_tuser, mon_ev.pin, mon_ev.pressed));
                    if (o_m_tlast !== mon_ev.last)
                        flag_mismatch($sformatf("tlast %b on pin %0d, expected %b",
                                                o_m_tlast, mon_ev.pin, mon_ev.last));
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("** shift_input_change_events_top: FAILED **");
                    $finish;
                end
            end
        end
    end

    // valid stays up from one beat to the next unless a gap is drawn
    task automatic send_item(input logic [OP_W-1:0] op, input logic [MOD_W-1:0] m,
                             input logic [7:0] lv, input logic typed = 1'b0,
                             input logic [3:0] count = 4'd0,
                             input logic [PIN_W-1:0] pin = '0, input logic pr = 1'b0);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid       <= 1'b1;
        i_s_tuser        <= op;
        i_s_tdata        <= {5'd0, lv, m};
        directed_check   <= typed;
        directed_count   <= count;
        directed_pin     <= pin;
        directed_pressed <= pr;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (items_sent < PHASE_LEN) begin
            send_idle = 25;
            recv_idle = 82;
        end else if (items_sent < 2 * PHASE_LEN) begin
            send_idle = 82;
            recv_idle = 25;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // hold the input off until every pending event is out, then let the scanner settle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setting(input t_cfg_set s);
        logic [31:0] rnd;
        rnd = $urandom;
        wait_drained();
        write_reg(REG_DEBOUNCE, s.deb);
        // upper data bits are don't-care for the narrow registers
        write_reg(REG_MODCOUNT, {rnd[3:0], s.cnt[3:0]});
        write_reg(REG_PRESS_EN, {rnd[10:4], s.pen[0]});
        write_reg(REG_RELEA_EN, {rnd[17:11], s.ren[0]});
        write_reg(REG_UNUSED, rnd[31:24]);
        i_cfg_valid <= 1'b0;
    endtask

    // ticks that usually open the gate, then one byte per module in order
    task automatic run_scan();
        int          ticks;
        int          mods;
        logic [31:0] rnd;
        logic [7:0]  flips;
        mods = active_mods();
        if (cfg_debounce == ELAPSED_MAX)
            ticks = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 80)
            ticks = int'(cfg_debounce) + 1;
        else
            ticks = $urandom_range(0, int'(cfg_debounce) + 1);
        repeat (ticks) begin
            rnd = $urandom;
            send_item(OP_TICK, rnd[2:0], rnd[10:3]);
        end
        for (int m = 0; m < mods; m++) begin
            rnd = $urandom;
            flips = 8'd1 << rnd[2:0];
            if (rnd[3])
                flips = flips | (8'd1 << rnd[6:4]);
            send_item(OP_BYTE, m[MOD_W-1:0],
                      (rnd[9:7] < 3'd5) ? (mirror_levels[m] ^ flips) : rnd[31:24]);
        end
    endtask

    initial begin
        t_dir_row    row;
        logic        cfg_open;
        int          start;
        logic [31:0] rnd;
        i_rst_n          <= 1'b0;
        i_s_tvalid       <= 1'b0;
        i_s_tdata        <= '0;
        i_s_tuser        <= OP_TICK;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= REG_DEBOUNCE;
        i_cfg_data       <= '0;
        directed_check   <= 1'b0;
        directed_count   <= '0;
        directed_pin     <= '0;
        directed_pressed <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        for (int i = 0; i < NUM_DIR; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open)
                    wait_drained();
                write_reg(row.idx, row.val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open)
                    i_cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_item(row.op, row.mod, row.val, row.typed, row.count, row.pin,
                          row.pressed);
            end
        end

        for (int s = 0; s < NUM_SETS; s++) begin
            apply_setting(RAND_SETS[s]);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_SET) begin
                if ($urandom_range(0, 99) < 75) begin
                    run_scan();
                end else begin
                    rnd = $urandom;
                    if (rnd[20:16] == 5'd0)
                        send_item(OP_CLEAR, rnd[4:2], rnd[12:5]);
                    else
                        send_item(rnd[1:0], rnd[4:2], rnd[12:5]);
                end
                if ($urandom_range(0, 99) < 3)
                    wait_drained();
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("** shift_input_change_events_top: PASSED **");
        else
            $display("** shift_input_change_events_top: FAILED **");
        $finish;
    end

endmodule
